@@ src/mfde_pkg.sv @@
// ----------------------------------------------------------------------------
// mfde_pkg
// Shared types, codes and the 5x7 glyph table of the monochrome draw engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mfde_pkg;

  // default panel size
  localparam int DEF_WIDTH  = 128;
  localparam int DEF_HEIGHT = 64;

  // internal coordinate width (covers corner plus size minus one)
  localparam int CW = 12;

  // glyph constants
  localparam int GLYPH_FIRST = 32;
  localparam int GLYPH_LAST  = 126;
  localparam int GLYPH_COLS  = 5;
  localparam int GLYPH_ROWS  = 7;

  // command codes on the func port
  localparam logic [2:0] FUNC_CLEAR   = 3'd0;
  localparam logic [2:0] FUNC_PIXEL   = 3'd1;
  localparam logic [2:0] FUNC_LINE    = 3'd2;
  localparam logic [2:0] FUNC_FILL    = 3'd3;
  localparam logic [2:0] FUNC_OUTLINE = 3'd4;
  localparam logic [2:0] FUNC_GLYPH   = 3'd5;
  localparam logic [2:0] FUNC_READ    = 3'd6;

  // classified operation handed to the back end
  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_PIXEL,
    OP_LINE,
    OP_FILL,
    OP_OUTLINE,
    OP_GLYPH,
    OP_READ
  } op_t;

  // back end sequencer states
  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CLR,
    S_RD,
    S_RDW,
    S_PIX,
    S_LSET,
    S_LINE,
    S_FILL,
    S_GLY,
    S_WR,
    S_DONE
  } state_t;

  // one queued item
  typedef struct packed {
    op_t                  op;
    logic                 status;
    logic                 color;
    logic signed [CW-1:0] x0;
    logic signed [CW-1:0] y0;
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
    logic [39:0]          glyph;
    logic [1:0]           scale;
    logic [9:0]           addr;
    logic                 addr_ok;
  } entry_t;

  // glyph columns, column 0 in the top byte, bit 0 is the top row
  function automatic logic [39:0] glyph_rom(input logic [6:0] idx);
    logic [39:0] r;
    case (idx)
      7'd0:  r = 40'h0000000000;
      7'd1:  r = 40'h00005f0000;
      7'd2:  r = 40'h0007000700;
      7'd3:  r = 40'h147f147f14;
      7'd4:  r = 40'h242a7f2a12;
      7'd5:  r = 40'h2313086462;
      7'd6:  r = 40'h3649552250;
      7'd7:  r = 40'h0005030000;
      7'd8:  r = 40'h001c224100;
      7'd9:  r = 40'h0041221c00;
      7'd10: r = 40'h14083e0814;
      7'd11: r = 40'h08083e0808;
      7'd12: r = 40'h0000a06000;
      7'd13: r = 40'h0808080808;
      7'd14: r = 40'h0060600000;
      7'd15: r = 40'h2010080402;
      7'd16: r = 40'h3e5149453e;
      7'd17: r = 40'h00427f4000;
      7'd18: r = 40'h4261514946;
      7'd19: r = 40'h2141454b31;
      7'd20: r = 40'h1814127f10;
      7'd21: r = 40'h2745454539;
      7'd22: r = 40'h3c4a494930;
      7'd23: r = 40'h0171090503;
      7'd24: r = 40'h3649494936;
      7'd25: r = 40'h064949291e;
      7'd26: r = 40'h0036360000;
      7'd27: r = 40'h0056360000;
      7'd28: r = 40'h0814224100;
      7'd29: r = 40'h1414141414;
      7'd30: r = 40'h0041221408;
      7'd31: r = 40'h0201510906;
      7'd32: r = 40'h324979413e;
      7'd33: r = 40'h7e1111117e;
      7'd34: r = 40'h7f49494936;
      7'd35: r = 40'h3e41414122;
      7'd36: r = 40'h7f4141221c;
      7'd37: r = 40'h7f49494941;
      7'd38: r = 40'h7f09090901;
      7'd39: r = 40'h3e4149497a;
      7'd40: r = 40'h7f0808087f;
      7'd41: r = 40'h00417f4100;
      7'd42: r = 40'h2040413f01;
      7'd43: r = 40'h7f08142241;
      7'd44: r = 40'h7f40404040;
      7'd45: r = 40'h7f020c027f;
      7'd46: r = 40'h7f0408107f;
      7'd47: r = 40'h3e4141413e;
      7'd48: r = 40'h7f09090906;
      7'd49: r = 40'h3e4151215e;
      7'd50: r = 40'h7f09192946;
      7'd51: r = 40'h4649494931;
      7'd52: r = 40'h01017f0101;
      7'd53: r = 40'h3f4040403f;
      7'd54: r = 40'h1f2040201f;
      7'd55: r = 40'h3f4038403f;
      7'd56: r = 40'h6314081463;
      7'd57: r = 40'h0708700807;
      7'd58: r = 40'h6151494543;
      7'd59: r = 40'h007f414100;
      7'd60: r = 40'h0204081020;
      7'd61: r = 40'h0041417f00;
      7'd62: r = 40'h0402010204;
      7'd63: r = 40'h4040404040;
      7'd64: r = 40'h0001020400;
      7'd65: r = 40'h2054545478;
      7'd66: r = 40'h7f48444438;
      7'd67: r = 40'h3844444420;
      7'd68: r = 40'h384444487f;
      7'd69: r = 40'h3854545418;
      7'd70: r = 40'h087e090102;
      7'd71: r = 40'h18a4a4a47c;
      7'd72: r = 40'h7f08040478;
      7'd73: r = 40'h00447d4000;
      7'd74: r = 40'h4080847d00;
      7'd75: r = 40'h7f10284400;
      7'd76: r = 40'h00417f4000;
      7'd77: r = 40'h7c04180478;
      7'd78: r = 40'h7c08040478;
      7'd79: r = 40'h3844444438;
      7'd80: r = 40'hfc24242418;
      7'd81: r = 40'h18242418fc;
      7'd82: r = 40'h7c08040408;
      7'd83: r = 40'h4854545420;
      7'd84: r = 40'h043f444020;
      7'd85: r = 40'h3c4040207c;
      7'd86: r = 40'h1c2040201c;
      7'd87: r = 40'h3c4030403c;
      7'd88: r = 40'h4428102844;
      7'd89: r = 40'h1ca0a0a07c;
      7'd90: r = 40'h4464544c44;
      7'd91: r = 40'h0008364100;
      7'd92: r = 40'h00007f0000;
      7'd93: r = 40'h0041360800;
      7'd94: r = 40'h1008081008;
      default: r = 40'h0000000000;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/mfde_ram.sv @@
// ----------------------------------------------------------------------------
// mfde_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mfde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ src/mfde_front.sv @@
// ----------------------------------------------------------------------------
// mfde_front
// Classifies an incoming command: clips fill areas, checks the pixel and read
// address ranges, looks up the glyph columns and builds one queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module mfde_front
  import mfde_pkg::*;
#(
  parameter int DISPLAY_WIDTH  = DEF_WIDTH,
  parameter int DISPLAY_HEIGHT = DEF_HEIGHT
) (
  input  wire logic               [2:0] func,
  input  wire logic signed        [9:0] x_a,
  input  wire logic signed        [9:0] y_a,
  input  wire logic signed        [9:0] x_b,
  input  wire logic signed        [9:0] y_b,
  input  wire logic               [8:0] rect_width,
  input  wire logic               [8:0] rect_height,
  input  wire logic                     color,
  input  wire logic               [7:0] char_code,
  input  wire logic               [1:0] font_size,
  input  wire logic               [9:0] read_address,
  output entry_t                        entry
);

  localparam int STORE_BYTES = DISPLAY_WIDTH * ((DISPLAY_HEIGHT + 7) / 8);
  localparam logic signed [CW-1:0] W_S = CW'(DISPLAY_WIDTH);
  localparam logic signed [CW-1:0] H_S = CW'(DISPLAY_HEIGHT);

  logic signed [CW-1:0] xa, ya, xb, yb, ws, hs;
  logic signed [CW-1:0] xe, ye, fx0, fy0, fx1, fy1;
  logic                 on_scr;

  // widen coordinates and sizes
  assign xa = CW'(x_a);
  assign ya = CW'(y_a);
  assign xb = CW'(x_b);
  assign yb = CW'(y_b);
  assign ws = $signed({{(CW-9){1'b0}}, rect_width});
  assign hs = $signed({{(CW-9){1'b0}}, rect_height});

  // rectangle clipping
  assign xe  = xa + ws;
  assign ye  = ya + hs;
  assign fx0 = (xa < 0) ? '0 : xa;
  assign fy0 = (ya < 0) ? '0 : ya;
  assign fx1 = (xe > W_S) ? W_S : xe;
  assign fy1 = (ye > H_S) ? H_S : ye;

  assign on_scr = (xa >= 0) && (xa < W_S) && (ya >= 0) && (ya < H_S);

  // build the entry
  always_comb begin
    entry         = '0;
    entry.op      = OP_NONE;
    entry.color   = color;
    entry.x0      = xa;
    entry.y0      = ya;
    entry.x1      = xb;
    entry.y1      = yb;
    entry.addr    = read_address;
    entry.addr_ok = (32'(read_address) < 32'(STORE_BYTES));
    entry.scale   = (font_size == 2'd1) ? 2'd2 : ((font_size == 2'd2) ? 2'd3 : 2'd1);
    entry.glyph   = glyph_rom(7'(char_code - 8'(GLYPH_FIRST)));
    case (func)
      FUNC_CLEAR: begin
        entry.op = OP_CLEAR;
      end
      FUNC_PIXEL: begin
        entry.op     = on_scr ? OP_PIXEL : OP_NONE;
        entry.status = !on_scr;
      end
      FUNC_LINE: begin
        entry.op = OP_LINE;
      end
      FUNC_FILL: begin
        entry.x0 = fx0;
        entry.y0 = fy0;
        entry.x1 = fx1;
        entry.y1 = fy1;
        entry.op = ((fx0 < fx1) && (fy0 < fy1)) ? OP_FILL : OP_NONE;
      end
      FUNC_OUTLINE: begin
        entry.x1 = xe - CW'(1);
        entry.y1 = ye - CW'(1);
        entry.op = OP_OUTLINE;
      end
      FUNC_GLYPH: begin
        entry.op = ((char_code >= 8'(GLYPH_FIRST)) && (char_code <= 8'(GLYPH_LAST)))
                   ? OP_GLYPH : OP_NONE;
      end
      FUNC_READ: begin
        entry.op = OP_READ;
      end
      default: begin
        entry.op = OP_NONE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/mfde_queue.sv @@
// ----------------------------------------------------------------------------
// mfde_queue
// Two-entry item queue between the classifying front and the drawing back.
// ----------------------------------------------------------------------------
`default_nettype none

module mfde_queue
  import mfde_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_entry,
  input  wire logic   pop,
  output entry_t      head,
  output logic        full,
  output logic        empty
);

  entry_t     slots [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign head  = slots[rptr];
  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_entry;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/mfde_back.sv @@
// ----------------------------------------------------------------------------
// mfde_back
// Drawing back end: walks the pixels of each queued item (line stepper,
// rectangle raster, glyph scan) and does one read-modify-write per drawn pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module mfde_back
  import mfde_pkg::*;
#(
  parameter int DISPLAY_WIDTH  = DEF_WIDTH,
  parameter int DISPLAY_HEIGHT = DEF_HEIGHT
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   q_empty,
  input  wire entry_t q_head,
  output logic        q_pop,
  output logic        init_busy,
  output logic        done,
  output logic  [7:0] read_data,
  output logic        status
);

  localparam int STORE_BYTES = DISPLAY_WIDTH * ((DISPLAY_HEIGHT + 7) / 8);
  localparam int AW          = $clog2(STORE_BYTES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);
  localparam logic signed [CW-1:0] W_S = CW'(DISPLAY_WIDTH);
  localparam logic signed [CW-1:0] H_S = CW'(DISPLAY_HEIGHT);

  state_t state, state_next, ret;
  entry_t ent;

  logic [AW-1:0] cnt;
  logic [7:0]    res_data;
  logic          res_status;

  // latched pixel for the write cycle
  logic [AW-1:0] pidx;
  logic [7:0]    pbit;
  logic          pcol;

  // line stepper
  logic signed [CW-1:0] lx, ly, lx1, ly1;
  logic signed [CW:0]   ldx, ldy;
  logic                 lsxn, lsyn;
  logic signed [CW+2:0] lerr, lerr_next;
  logic signed [CW+3:0] le2;
  logic                 lc1, lc2, l_last;
  logic [1:0]           seg;

  // line setup
  logic signed [CW-1:0] sx0, sy0, sx1, sy1;
  logic signed [CW:0]   ddx, ddy, adx, ady;

  // rectangle raster
  logic signed [CW-1:0] px, py;
  logic                 f_last;

  // glyph scan
  logic [2:0] gi, gj;
  logic [1:0] si, sj, scm1;
  logic [4:0] goff_x, goff_y;
  logic       gbit, gcell_last, gadv, g_last;

  // current pixel
  logic signed [CW-1:0] pix_x, pix_y;
  logic                 pix_on;
  logic [AW-1:0]        pix_idx;
  logic [7:0]           pix_mask;
  state_t               gen_next;

  // memory port
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  mfde_ram #(
    .WIDTH(8),
    .DEPTH(STORE_BYTES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // line endpoints per outline edge
  always_comb begin
    sx0 = ent.x0;
    sy0 = ent.y0;
    sx1 = ent.x1;
    sy1 = ent.y1;
    if (ent.op == OP_OUTLINE) begin
      case (seg)
        2'd0: begin
          sx1 = ent.x1;
          sy1 = ent.y0;
        end
        2'd1: begin
          sx1 = ent.x0;
          sy1 = ent.y1;
        end
        2'd2: begin
          sx0 = ent.x1;
          sy0 = ent.y0;
        end
        default: begin
          sx0 = ent.x0;
          sy0 = ent.y1;
        end
      endcase
    end
    ddx = (CW+1)'(sx1) - (CW+1)'(sx0);
    ddy = (CW+1)'(sy1) - (CW+1)'(sy0);
    adx = (ddx < 0) ? -ddx : ddx;
    ady = (ddy < 0) ? -ddy : ddy;
  end

  // line step decision
  always_comb begin
    le2    = (CW+4)'(lerr) <<< 1;
    lc1    = le2 > -((CW+4)'(ldy));
    lc2    = le2 < (CW+4)'(ldx);
    lerr_next = lerr;
    if (lc1) begin
      lerr_next = lerr_next - (CW+3)'(ldy);
    end
    if (lc2) begin
      lerr_next = lerr_next + (CW+3)'(ldx);
    end
    l_last = (lx == lx1) && (ly == ly1);
  end

  // rectangle and glyph progress
  assign f_last     = (px == ent.x1 - CW'(1)) && (py == ent.y1 - CW'(1));
  assign scm1       = ent.scale - 2'd1;
  assign gbit       = ent.glyph[{3'(3'(GLYPH_COLS - 1) - gi), gj}];
  assign gcell_last = (si == scm1) && (sj == scm1);
  assign gadv       = !gbit || gcell_last;
  assign g_last     = gadv && (gi == 3'(GLYPH_COLS - 1)) && (gj == 3'(GLYPH_ROWS - 1));
  assign goff_x     = 5'(gi) * 5'(ent.scale) + 5'(si);
  assign goff_y     = 5'(gj) * 5'(ent.scale) + 5'(sj);

  // current pixel and what follows it
  always_comb begin
    pix_x    = ent.x0;
    pix_y    = ent.y0;
    gen_next = S_DONE;
    case (state)
      S_LINE: begin
        pix_x    = lx;
        pix_y    = ly;
        gen_next = !l_last ? S_LINE
                 : (((ent.op == OP_OUTLINE) && (seg != 2'd3)) ? S_LSET : S_DONE);
      end
      S_FILL: begin
        pix_x    = px;
        pix_y    = py;
        gen_next = f_last ? S_DONE : S_FILL;
      end
      S_GLY: begin
        pix_x    = ent.x0 + $signed({{(CW-5){1'b0}}, goff_x});
        pix_y    = ent.y0 + $signed({{(CW-5){1'b0}}, goff_y});
        gen_next = g_last ? S_DONE : S_GLY;
      end
      default: begin
        gen_next = S_DONE;
      end
    endcase
    pix_on = (pix_x >= 0) && (pix_x < W_S) && (pix_y >= 0) && (pix_y < H_S)
             && ((state != S_GLY) || gbit);
  end

  assign pix_idx  = AW'(pix_y[CW-1:3]) * AW'(DISPLAY_WIDTH) + AW'(pix_x[CW-1:0]);
  assign pix_mask = 8'd1 << pix_y[2:0];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_INIT: begin
        state_next = (cnt == LAST_ADDR) ? S_IDLE : S_INIT;
      end
      S_IDLE: begin
        if (!q_empty) begin
          case (q_head.op)
            OP_CLEAR:   state_next = S_CLR;
            OP_PIXEL:   state_next = S_PIX;
            OP_LINE:    state_next = S_LSET;
            OP_OUTLINE: state_next = S_LSET;
            OP_FILL:    state_next = S_FILL;
            OP_GLYPH:   state_next = S_GLY;
            OP_READ:    state_next = S_RD;
            default:    state_next = S_DONE;
          endcase
        end
      end
      S_CLR: begin
        state_next = (cnt == LAST_ADDR) ? S_DONE : S_CLR;
      end
      S_RD: begin
        state_next = S_RDW;
      end
      S_RDW: begin
        state_next = S_DONE;
      end
      S_LSET: begin
        state_next = S_LINE;
      end
      S_PIX, S_LINE, S_FILL, S_GLY: begin
        state_next = pix_on ? S_WR : gen_next;
      end
      S_WR: begin
        state_next = ret;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // outputs and memory controls
  always_comb begin
    q_pop     = (state == S_IDLE) && !q_empty;
    init_busy = (state == S_INIT);
    done      = (state == S_DONE);
    read_data = res_data;
    status    = res_status;
    ram_raddr = (state == S_RD) ? AW'(ent.addr) : pix_idx;
    ram_we    = 1'b0;
    ram_waddr = cnt;
    ram_wdata = 8'd0;
    case (state)
      S_INIT, S_CLR: begin
        ram_we = 1'b1;
      end
      S_WR: begin
        ram_we    = 1'b1;
        ram_waddr = pidx;
        ram_wdata = pcol ? (ram_rdata | pbit) : (ram_rdata & ~pbit);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // state and sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if ((state == S_INIT) || (state == S_CLR)) begin
        cnt <= (cnt == LAST_ADDR) ? '0 : cnt + AW'(1);
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (!q_empty) begin
          ent        <= q_head;
          res_data   <= 8'd0;
          res_status <= q_head.status;
          seg        <= 2'd0;
          px         <= q_head.x0;
          py         <= q_head.y0;
          gi         <= 3'd0;
          gj         <= 3'd0;
          si         <= 2'd0;
          sj         <= 2'd0;
        end
      end
      S_RDW: begin
        res_data <= ent.addr_ok ? ram_rdata : 8'd0;
      end
      S_LSET: begin
        lx   <= sx0;
        ly   <= sy0;
        lx1  <= sx1;
        ly1  <= sy1;
        ldx  <= adx;
        ldy  <= ady;
        lsxn <= !(sx0 < sx1);
        lsyn <= !(sy0 < sy1);
        lerr <= (CW+3)'(adx) - (CW+3)'(ady);
      end
      default: begin
      end
    endcase

    // latch the pixel for its write cycle
    if ((state == S_PIX) || (state == S_LINE) || (state == S_FILL) || (state == S_GLY)) begin
      ret  <= gen_next;
      pidx <= pix_idx;
      pbit <= pix_mask;
      pcol <= (state == S_GLY) ? 1'b1 : ent.color;
    end

    // line step
    if (state == S_LINE) begin
      if (l_last) begin
        seg <= seg + 2'd1;
      end else begin
        lerr <= lerr_next;
        if (lc1) begin
          lx <= lsxn ? lx - CW'(1) : lx + CW'(1);
        end
        if (lc2) begin
          ly <= lsyn ? ly - CW'(1) : ly + CW'(1);
        end
      end
    end

    // rectangle raster step
    if (state == S_FILL) begin
      if (px == ent.x1 - CW'(1)) begin
        px <= ent.x0;
        py <= py + CW'(1);
      end else begin
        px <= px + CW'(1);
      end
    end

    // glyph scan step
    if (state == S_GLY) begin
      if (gadv) begin
        si <= 2'd0;
        sj <= 2'd0;
        if (gj == 3'(GLYPH_ROWS - 1)) begin
          gj <= 3'd0;
          gi <= gi + 3'd1;
        end else begin
          gj <= gj + 3'd1;
        end
      end else if (sj == scm1) begin
        sj <= 2'd0;
        si <= si + 2'd1;
      end else begin
        sj <= sj + 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/mono_framebuffer_draw_engine_core.sv @@
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine_core
// Drawing engine over a page-organised monochrome frame store.
// ----------------------------------------------------------------------------
// Usage: a command item is taken on a rising edge with start high and busy
// low; its fields are func and the coordinate, size, colour, glyph and read
// address ports. Each item gives one result: done is high for exactly one
// cycle with read_data (read command, else zero) and status (pixel command
// off screen). The receiver cannot stall, so results are never held.
// The front classifies items into a two-entry queue; busy is high while the
// queue is full or while the store is swept after reset.
// Time per item is set by the read-modify-write on the store: each drawn
// pixel is read in its generating state and written back in S_WR, while a
// clipped line pixel or blank glyph cell is passed over with no write. A
// line or outline sets up each edge in S_LSET, an off-screen pixel goes
// straight to done, and a clear sweeps the whole store to zero.
// Reset: synchronous; after it the store is swept to zero, one byte a cycle,
// with busy high throughout.
// ----------------------------------------------------------------------------
`default_nettype none

module mono_framebuffer_draw_engine_core
  import mfde_pkg::*;
#(
  parameter int DISPLAY_WIDTH  = DEF_WIDTH,
  parameter int DISPLAY_HEIGHT = DEF_HEIGHT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic        [2:0] func,
  input  wire logic signed [9:0] x_a,
  input  wire logic signed [9:0] y_a,
  input  wire logic signed [9:0] x_b,
  input  wire logic signed [9:0] y_b,
  input  wire logic        [8:0] rect_width,
  input  wire logic        [8:0] rect_height,
  input  wire logic              color,
  input  wire logic        [7:0] char_code,
  input  wire logic        [1:0] font_size,
  input  wire logic        [9:0] read_address,
  output logic                   done,
  output logic             [7:0] read_data,
  output logic                   status
);

  entry_t f_entry, q_head;
  logic   q_full, q_empty, q_pop, init_busy, accept;

  // item handshake
  assign busy   = q_full || init_busy;
  assign accept = start && !busy;

  mfde_front #(
    .DISPLAY_WIDTH (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT(DISPLAY_HEIGHT)
  ) u_front (
    .func        (func),
    .x_a         (x_a),
    .y_a         (y_a),
    .x_b         (x_b),
    .y_b         (y_b),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .color       (color),
    .char_code   (char_code),
    .font_size   (font_size),
    .read_address(read_address),
    .entry       (f_entry)
  );

  mfde_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_entry(f_entry),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  mfde_back #(
    .DISPLAY_WIDTH (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT(DISPLAY_HEIGHT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .init_busy(init_busy),
    .done     (done),
    .read_data(read_data),
    .status   (status)
  );

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Checks the monochrome draw engine against its own copy of the frame store.
// Every command item is mirrored into a behavioural store, and each result
// (read byte and pixel status) is compared with the one predicted for it.
// Mostly small shapes in and around the screen, with read-backs in between.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import mfde_pkg::*;

  localparam int WIDTH       = DEF_WIDTH;
  localparam int HEIGHT      = DEF_HEIGHT;
  localparam int STORE_BYTES = WIDTH * ((HEIGHT + 7) / 8);
  localparam int N_RANDOM    = 1025;
  localparam int QUIET_LIMIT = 200000;
  localparam int FUNC_UNUSED = 7;

  // 5x7 font, entry 0 in the top bits, column 0 in the top byte of an entry
  localparam logic [95*40-1:0] FONT = {
    40'h0000000000, 40'h00005f0000, 40'h0007000700, 40'h147f147f14, 40'h242a7f2a12,
    40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001c224100, 40'h0041221c00,
    40'h14083e0814, 40'h08083e0808, 40'h0000a06000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
    40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503, 40'h3649494936,
    40'h064949291e, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324979413e, 40'h7e1111117e, 40'h7f49494936,
    40'h3e41414122, 40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
    40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241, 40'h7f40404040,
    40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e, 40'h7f09090906, 40'h3e4151215e,
    40'h7f09192946, 40'h4649494931, 40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f,
    40'h3f4038403f, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
    40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
    40'h2054545478, 40'h7f48444438, 40'h3844444420, 40'h384444487f, 40'h3854545418,
    40'h087e090102, 40'h18a4a4a47c, 40'h7f08040478, 40'h00447d4000, 40'h4080847d00,
    40'h7f10284400, 40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
    40'hfc24242418, 40'h18242418fc, 40'h7c08040408, 40'h4854545420, 40'h043f444020,
    40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c, 40'h4428102844, 40'h1ca0a0a07c,
    40'h4464544c44, 40'h0008364100, 40'h00007f0000, 40'h0041360800, 40'h1008081008
  };

  typedef struct {
    logic        [2:0] func;
    logic signed [9:0] xa, ya, xb, yb;
    logic        [8:0] w, h;
    logic              color;
    logic        [7:0] code;
    logic        [1:0] size;
    logic        [9:0] addr;
  } cmd_t;

  typedef struct {
    logic [7:0] data;
    logic       flag;
  } answer_t;

  // behavioural frame store and queue of predicted answers
  class draw_scoreboard;
    logic [7:0] pixels [STORE_BYTES];
    answer_t    answers [$];
    int         fails;
    int         checked;

    function new();
      foreach (pixels[i]) pixels[i] = '0;
      fails   = 0;
      checked = 0;
    endfunction

    function int pending();
      return answers.size();
    endfunction

    function bit plot(int x, int y, logic c);
      int idx;
      if (x < 0 || x >= WIDTH || y < 0 || y >= HEIGHT) return 0;
      idx = (y / 8) * WIDTH + x;
      pixels[idx][y % 8] = c;
      return 1;
    endfunction

    function void line(int x0, int y0, int x1, int y1, logic c);
      int dx, dy, sx, sy, err, e2;
      bit ok;
      dx  = x1 > x0 ? x1 - x0 : x0 - x1;
      dy  = y1 > y0 ? y1 - y0 : y0 - y1;
      sx  = x0 < x1 ? 1 : -1;
      sy  = y0 < y1 ? 1 : -1;
      err = dx - dy;
      forever begin
        ok = plot(x0, y0, c);
        if (x0 == x1 && y0 == y1) break;
        e2 = 2 * err;
        if (e2 > -dy) begin
          err -= dy;
          x0  += sx;
        end
        if (e2 < dx) begin
          err += dx;
          y0  += sy;
        end
      end
    endfunction

    function void glyph(int x, int y, logic [7:0] code, logic [1:0] size);
      int         sc;
      logic [39:0] cols;
      bit         ok;
      if (code < GLYPH_FIRST || code > GLYPH_LAST) return;
      sc   = size == 2'd1 ? 2 : (size == 2'd2 ? 3 : 1);
      cols = FONT[(94 - (code - GLYPH_FIRST)) * 40 +: 40];
      for (int i = 0; i < GLYPH_COLS; i++)
        for (int j = 0; j < GLYPH_ROWS; j++)
          if (cols[39 - 8 * i - 7 + j])
            for (int si = 0; si < sc; si++)
              for (int sj = 0; sj < sc; sj++)
                ok = plot(x + i * sc + si, y + j * sc + sj, 1'b1);
    endfunction

    // apply an accepted item and queue its answer
    function void note(cmd_t c);
      answer_t a;
      int      xa, ya, xb, yb, w, h, xe, ye;
      bit      ok;
      a.data = '0;
      a.flag = 1'b0;
      xa = int'(c.xa);
      ya = int'(c.ya);
      xb = int'(c.xb);
      yb = int'(c.yb);
      w  = int'(c.w);
      h  = int'(c.h);
      case (c.func)
        FUNC_CLEAR: foreach (pixels[i]) pixels[i] = '0;
        FUNC_PIXEL: a.flag = !plot(xa, ya, c.color);
        FUNC_LINE:  line(xa, ya, xb, yb, c.color);
        FUNC_FILL: begin
          xe = xa + w > WIDTH ? WIDTH : xa + w;
          ye = ya + h > HEIGHT ? HEIGHT : ya + h;
          for (int py = (ya < 0 ? 0 : ya); py < ye; py++)
            for (int px = (xa < 0 ? 0 : xa); px < xe; px++)
              ok = plot(px, py, c.color);
        end
        FUNC_OUTLINE: begin
          line(xa, ya, xa + w - 1, ya, c.color);
          line(xa, ya, xa, ya + h - 1, c.color);
          line(xa + w - 1, ya, xa + w - 1, ya + h - 1, c.color);
          line(xa, ya + h - 1, xa + w - 1, ya + h - 1, c.color);
        end
        FUNC_GLYPH: glyph(xa, ya, c.code, c.size);
        FUNC_READ:  if (c.addr < STORE_BYTES) a.data = pixels[c.addr];
        default: ;
      endcase
      answers.push_back(a);
    endfunction

    function void check(logic [7:0] data, logic flag);
      answer_t a;
      if (answers.size() == 0) begin
        $error("result with no item outstanding: read_data %0h status %0b", data, flag);
        fails++;
        return;
      end
      a = answers.pop_front();
      checked++;
      if (data !== a.data) begin
        $error("read_data: expected %0h, got %0h", a.data, data);
        fails++;
      end
      if (flag !== a.flag) begin
        $error("status: expected %0b, got %0b", a.flag, flag);
        fails++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              start;
  logic              busy;
  logic        [2:0] func;
  logic signed [9:0] x_a, y_a, x_b, y_b;
  logic        [8:0] rect_width, rect_height;
  logic              color;
  logic        [7:0] char_code;
  logic        [1:0] font_size;
  logic        [9:0] read_address;
  logic              done;
  logic        [7:0] read_data;
  logic              status;

  draw_scoreboard sb = new();
  int             idle_pct;
  int             func_count [8];
  int             quiet;

  mono_framebuffer_draw_engine_core dut (
    .clk, .rst, .start, .busy, .func, .x_a, .y_a, .x_b, .y_b,
    .rect_width, .rect_height, .color, .char_code, .font_size,
    .read_address, .done, .read_data, .status
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && done) sb.check(read_data, status);
  end

  // watchdog on cycles with no handshake at all
  initial begin
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((start && !busy) || done) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  // drive one item and wait for it to be taken, then maybe leave a gap
  task automatic issue(cmd_t c);
    int gap;
    func         <= c.func;
    x_a          <= c.xa;
    y_a          <= c.ya;
    x_b          <= c.xb;
    y_b          <= c.yb;
    rect_width   <= c.w;
    rect_height  <= c.h;
    color        <= c.color;
    char_code    <= c.code;
    font_size    <= c.size;
    read_address <= c.addr;
    start        <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note(c);
    func_count[c.func]++;
    if ($urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 8);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic directed(logic [2:0] f, int xa, int ya, int xb, int yb, int w, int h,
                          logic c, int code, int size, int addr);
    cmd_t k;
    k.func  = f;
    k.xa    = xa[9:0];
    k.ya    = ya[9:0];
    k.xb    = xb[9:0];
    k.yb    = yb[9:0];
    k.w     = w[8:0];
    k.h     = h[8:0];
    k.color = c;
    k.code  = code[7:0];
    k.size  = size[1:0];
    k.addr  = addr[9:0];
    issue(k);
  endtask

  // hold off until the engine has answered everything
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
  endtask

  function automatic cmd_t random_cmd();
    cmd_t c;
    int   r;
    c.func  = 3'($urandom);
    c.xa    = 10'($urandom);
    c.ya    = 10'($urandom);
    c.xb    = 10'($urandom);
    c.yb    = 10'($urandom);
    c.w     = 9'($urandom);
    c.h     = 9'($urandom);
    c.color = 1'($urandom);
    c.code  = 8'($urandom);
    c.size  = 2'($urandom);
    c.addr  = 10'($urandom);
    r = $urandom_range(0, 99);
    // keep most shapes near the screen so the run stays short
    if (r < 2) c.func = FUNC_CLEAR;
    else if (r < 20) begin
      c.func = FUNC_PIXEL;
      if ($urandom_range(0, 9) != 0) begin
        c.xa = 10'($urandom_range(0, WIDTH + 7) - 4);
        c.ya = 10'($urandom_range(0, HEIGHT + 7) - 4);
      end
    end else if (r < 32) begin
      c.func = FUNC_LINE;
      if ($urandom_range(0, 19) != 0) begin
        c.xa = 10'($urandom_range(0, WIDTH + 39) - 20);
        c.ya = 10'($urandom_range(0, HEIGHT + 39) - 20);
        c.xb = 10'($urandom_range(0, WIDTH + 39) - 20);
        c.yb = 10'($urandom_range(0, HEIGHT + 39) - 20);
      end
    end else if (r < 40) begin
      c.func = FUNC_FILL;
      c.xa   = 10'($urandom_range(0, WIDTH + 19) - 10);
      c.ya   = 10'($urandom_range(0, HEIGHT + 19) - 10);
      if ($urandom_range(0, 29) != 0) begin
        c.w = 9'($urandom_range(0, 24));
        c.h = 9'($urandom_range(0, 24));
      end
    end else if (r < 48) begin
      c.func = FUNC_OUTLINE;
      if ($urandom_range(0, 19) != 0) begin
        c.xa = 10'($urandom_range(0, WIDTH + 19) - 10);
        c.ya = 10'($urandom_range(0, HEIGHT + 19) - 10);
        c.w  = 9'($urandom_range(0, 40));
        c.h  = 9'($urandom_range(0, 40));
      end
    end else if (r < 58) begin
      c.func = FUNC_GLYPH;
      c.xa   = 10'($urandom_range(0, WIDTH + 19) - 10);
      c.ya   = 10'($urandom_range(0, HEIGHT + 19) - 10);
      if ($urandom_range(0, 4) != 0) c.code = 8'($urandom_range(28, 130));
    end else if (r < 60) c.func = 3'(FUNC_UNUSED);
    else c.func = FUNC_READ;
    return c;
  endfunction

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    func         = '0;
    x_a          = '0;
    y_a          = '0;
    x_b          = '0;
    y_b          = '0;
    rect_width   = '0;
    rect_height  = '0;
    color        = 1'b0;
    char_code    = '0;
    font_size    = '0;
    read_address = '0;
    idle_pct     = 31;
    foreach (func_count[i]) func_count[i] = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed corners: screen edges, clipping, degenerate shapes, glyph scales
    directed(FUNC_READ,       0,    0,   0,   0,   0,   0, 0,   0, 0, 0);
    directed(FUNC_PIXEL,      0,    0,   0,   0,   0,   0, 1,   0, 0, 0);
    directed(FUNC_PIXEL,    127,   63,   0,   0,   0,   0, 1,   0, 0, 0);
    directed(FUNC_PIXEL,     -1,    0,   0,   0,   0,   0, 1,   0, 0, 0);
    directed(FUNC_PIXEL,    128,    5,   0,   0,   0,   0, 1,   0, 0, 0);
    directed(FUNC_PIXEL,      0,   64,   0,   0,   0,   0, 1,   0, 0, 0);
    directed(FUNC_PIXEL,    511, -512,   0,   0,   0,   0, 1,   0, 0, 0);
    directed(FUNC_READ,       0,    0,   0,   0,   0,   0, 0,   0, 0, 0);
    directed(FUNC_READ,       0,    0,   0,   0,   0,   0, 0,   0, 0, 1023);
    directed(FUNC_LINE,    -512, -512, 511, 511,   0,   0, 1,   0, 0, 0);
    directed(FUNC_LINE,       9,    9,   9,   9,   0,   0, 1,   0, 0, 0);
    directed(FUNC_FILL,      20,   20,   0,   0,   0,   0, 1,   0, 0, 0);
    directed(FUNC_FILL,       0,    0,   0,   0, 511, 511, 1,   0, 0, 0);
    directed(FUNC_READ,       0,    0,   0,   0,   0,   0, 0,   0, 0, 515);
    directed(FUNC_FILL,      -5,   -5,   0,   0,  60,  30, 0,   0, 0, 0);
    directed(FUNC_OUTLINE,   40,   30,   0,   0,   0,   0, 0,   0, 0, 0);
    directed(FUNC_OUTLINE,   50,   10,   0,   0,   1,   3, 0,   0, 0, 0);
    directed(FUNC_GLYPH,     70,    0,   0,   0,   0,   0, 0,  65, 0, 0);
    directed(FUNC_GLYPH,     80,    8,   0,   0,   0,   0, 0, 126, 1, 0);
    directed(FUNC_GLYPH,     95,   40,   0,   0,   0,   0, 0, 103, 2, 0);
    directed(FUNC_GLYPH,    124,   60,   0,   0,   0,   0, 0,  64, 3, 0);
    directed(FUNC_GLYPH,     10,   50,   0,   0,   0,   0, 0,  31, 0, 0);
    directed(FUNC_GLYPH,     10,   50,   0,   0,   0,   0, 0, 127, 0, 0);
    directed(3'(FUNC_UNUSED), 0,    0,   0,   0,   0,   0, 1, 255, 3, 0);
    directed(FUNC_CLEAR,      0,    0,   0,   0,   0,   0, 0,   0, 0, 0);
    drain();

    // random part in three idling regimes
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 3) begin
        drain();
        idle_pct = 67;
      end else if (n == 2 * N_RANDOM / 3) begin
        drain();
        idle_pct = 0;
      end
      issue(random_cmd());
    end
    drain();
    repeat (50) @(posedge clk);

    $display("covered %0d results: clear %0d pixel %0d line %0d fill %0d outline %0d",
             sb.checked, func_count[FUNC_CLEAR], func_count[FUNC_PIXEL],
             func_count[FUNC_LINE], func_count[FUNC_FILL], func_count[FUNC_OUTLINE]);
    $display("glyph %0d read %0d unused code %0d", func_count[FUNC_GLYPH],
             func_count[FUNC_READ], func_count[FUNC_UNUSED]);
    if (sb.fails == 0 && sb.pending() == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
